// ===== src/tfcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_pkg: telemetry frame packer shared types and constants
// Request and frame byte structs, frame layout and crc-16 parameters.
// ----------------------------------------------------------------------------
package tfcp_pkg;

  localparam logic [7:0]  FrameFlag = 8'h93;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam int          BodyLen   = 24;
  localparam int          FrameLen  = 26;
  localparam int          IdxW      = $clog2(FrameLen);

  localparam logic [IdxW-1:0] CrcLoIdx = IdxW'(BodyLen);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(FrameLen - 1);

  typedef struct packed {
    logic        [7:0]  temperature_tenths;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic        [31:0] pressure;
    logic        [31:0] timestamp_ms;
  } rec_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frm_t;

endpackage

// ===== src/telemetry_frame_crc16_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_crc16_packer: sensor record to 26-byte crc-framed stream
// Each request yields a frame of 26 bytes, one byte per output request.
// ----------------------------------------------------------------------------
// a taken request passes the holding register and serializer into the frm register
// throughput: one frame byte per cycle while frm_stall is low, set by the
//   byte serializer that walks the frame and folds each body byte into the crc
// a second request is held in a one-entry input register while a frame streams
// reset (rst, synchronous): sequence number to 0, all valid flags cleared
module telemetry_frame_crc16_packer import tfcp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic rec_valid,
  output logic rec_stall,
  input  rec_t rec,
  output logic frm_valid,
  input  logic frm_stall,
  output frm_t frm
);

  // one crc-16 byte update, msb first, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] acc;
    acc = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CrcPoly;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    return acc;
  endfunction

  // input holding register
  logic pend_valid;
  rec_t pend;

  // frame currently being serialized
  logic            act_valid;
  rec_t            act_rec;
  logic [15:0]     act_seq;
  logic [IdxW-1:0] idx;
  logic [15:0]     crc;

  // running sequence count
  logic [15:0] seq;

  logic                       out_free;
  logic                       emit;
  logic                       act_done;
  logic                       load;
  logic [BodyLen-1:0][7:0]    body;
  logic [7:0]                 byte_sel;
  logic [15:0]                crc_next;

  // frame body layout, little-endian multi-byte fields
  always_comb begin
    body[0]  = FrameFlag;
    body[1]  = act_rec.temperature_tenths;
    body[2]  = act_rec.accel_x[7:0];
    body[3]  = act_rec.accel_x[15:8];
    body[4]  = act_rec.accel_y[7:0];
    body[5]  = act_rec.accel_y[15:8];
    body[6]  = act_rec.accel_z[7:0];
    body[7]  = act_rec.accel_z[15:8];
    body[8]  = act_rec.rate_x[7:0];
    body[9]  = act_rec.rate_x[15:8];
    body[10] = act_rec.rate_y[7:0];
    body[11] = act_rec.rate_y[15:8];
    body[12] = act_rec.rate_z[7:0];
    body[13] = act_rec.rate_z[15:8];
    body[14] = act_seq[7:0];
    body[15] = act_seq[15:8];
    body[16] = act_rec.timestamp_ms[7:0];
    body[17] = act_rec.timestamp_ms[15:8];
    body[18] = act_rec.timestamp_ms[23:16];
    body[19] = act_rec.timestamp_ms[31:24];
    body[20] = act_rec.pressure[7:0];
    body[21] = act_rec.pressure[15:8];
    body[22] = act_rec.pressure[23:16];
    body[23] = act_rec.pressure[31:24];
  end

  // pick the byte for this slot; crc trailer goes low byte first
  always_comb begin
    priority if (idx < CrcLoIdx) begin
      byte_sel = body[idx];
      crc_next = crc16_byte(crc, body[idx]);
    end else if (idx == CrcLoIdx) begin
      byte_sel = crc[7:0];
      crc_next = crc;
    end else begin
      byte_sel = crc[15:8];
      crc_next = crc;
    end
  end

  assign out_free  = !frm_valid || !frm_stall;
  assign emit      = act_valid && out_free;
  assign act_done  = emit && (idx == LastIdx);
  // next record moves in as soon as the serializer is free or on its last byte
  assign load      = pend_valid && (!act_valid || act_done);
  assign rec_stall = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      act_valid  <= 1'b0;
      frm_valid  <= 1'b0;
      seq        <= 16'h0000;
      idx        <= '0;
    end else begin
      // input holding register
      if (rec_valid && !rec_stall) begin
        pend_valid <= 1'b1;
        pend       <= rec;
      end else if (load) begin
        pend_valid <= 1'b0;
      end

      // serializer: load a new frame or step one byte
      if (load) begin
        act_valid <= 1'b1;
        act_rec   <= pend;
        act_seq   <= seq;
        seq       <= seq + 16'd1;
        idx       <= '0;
        crc       <= CrcInit;
      end else if (emit) begin
        idx <= idx + IdxW'(1);
        crc <= crc_next;
        if (act_done) begin
          act_valid <= 1'b0;
        end
      end

      // output register
      if (emit) begin
        frm_valid      <= 1'b1;
        frm.frame_byte <= byte_sel;
        frm.last_byte  <= (idx == LastIdx);
      end else if (out_free) begin
        frm_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/tfcp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_checker: port-level checks for the telemetry frame packer
// Tracks byte position in the output stream and checks frame framing.
// ----------------------------------------------------------------------------
module tfcp_checker import tfcp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rec_valid,
  input logic rec_stall,
  input logic frm_valid,
  input logic frm_stall,
  input frm_t frm
);

  logic            frm_take;
  logic [IdxW-1:0] pos;

  assign frm_take = frm_valid && !frm_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (frm_take) begin
      pos <= (pos == LastIdx) ? '0 : pos + IdxW'(1);
    end
  end

  // every frame opens with the flag byte
  a_flag_first: assert property (@(posedge clk) disable iff (rst)
    frm_take && pos == '0 |-> frm.frame_byte == FrameFlag)
    else $error("frame does not start with flag byte");

  // last marker exactly on the 26th byte
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    frm_take |-> (frm.last_byte == (pos == LastIdx)))
    else $error("last_byte out of place");

  // no output valid straight out of reset
  a_no_spurious: assert property (@(posedge clk)
    $past(rst) |-> !frm_valid)
    else $error("output valid right after reset");

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    frm_valid && frm_stall |=> frm_valid && $stable(frm))
    else $error("stalled frame byte changed");

  // a taken request fills the holding register, so the input stalls next cycle
  a_take_stalls: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_stall |=> rec_stall)
    else $error("input not stalled after a request was taken");

endmodule

bind telemetry_frame_crc16_packer tfcp_checker u_tfcp_checker (.*);

// ===== test/tfcp_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_frame_checker: frame stream scoreboard for the telemetry packer
// Watches both channels, builds the 26 expected frame bytes for every taken
// request and compares each delivered byte against the oldest one due.
// ----------------------------------------------------------------------------
module tfcp_frame_checker import tfcp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic rec_valid,
  input  logic rec_stall,
  input  rec_t rec,
  input  logic frm_valid,
  input  logic frm_stall,
  input  frm_t frm,
  output int   mismatches,
  output int   bytes_pending
);

  frm_t        frame_bytes_due[$];
  logic [15:0] seq_count;
  int          bad_count;

  // flag, temperature, six le16 values, le16 sequence, le32 time, le32 pressure,
  // then crc-16 over those 24 bytes, low byte first
  task automatic pack_expected_frame(input rec_t r);
    logic [7:0]  body [BodyLen];
    logic [15:0] crc;
    body[0] = FrameFlag;
    body[1] = r.temperature_tenths;
    {body[3], body[2]}   = r.accel_x;
    {body[5], body[4]}   = r.accel_y;
    {body[7], body[6]}   = r.accel_z;
    {body[9], body[8]}   = r.rate_x;
    {body[11], body[10]} = r.rate_y;
    {body[13], body[12]} = r.rate_z;
    {body[15], body[14]} = seq_count;
    {body[19], body[18], body[17], body[16]} = r.timestamp_ms;
    {body[23], body[22], body[21], body[20]} = r.pressure;
    crc = CrcInit;
    for (int k = 0; k < BodyLen; k++) begin
      crc = crc ^ {body[k], 8'h00};
      for (int b = 0; b < 8; b++) begin
        crc = crc[15] ? ((crc << 1) ^ CrcPoly) : (crc << 1);
      end
      frame_bytes_due.push_back(frm_t'{frame_byte: body[k], last_byte: 1'b0});
    end
    frame_bytes_due.push_back(frm_t'{frame_byte: crc[7:0], last_byte: 1'b0});
    frame_bytes_due.push_back(frm_t'{frame_byte: crc[15:8], last_byte: 1'b1});
    seq_count = seq_count + 16'd1;
  endtask

  always @(posedge clk) begin
    frm_t want;
    if (rst) begin
      seq_count = '0;
      frame_bytes_due.delete();
    end else begin
      // compare first: a byte leaving now can never belong to a request taken now
      if (frm_valid && !frm_stall) begin
        if (frame_bytes_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: unexpected frame byte %02h last %0b", $realtime,
                     frm.frame_byte, frm.last_byte);
        end else begin
          want = frame_bytes_due.pop_front();
          if (frm.frame_byte !== want.frame_byte || frm.last_byte !== want.last_byte) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t: frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                       $realtime, want.frame_byte, want.last_byte,
                       frm.frame_byte, frm.last_byte);
          end
        end
      end
      if (rec_valid && !rec_stall)
        pack_expected_frame(rec);
    end
    mismatches    <= bad_count;
    bytes_pending <= frame_bytes_due.size();
  end

endmodule

// ===== test/telemetry_frame_crc16_packer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_crc16_packer_test: stimulus and verdict for the frame packer
// Sends directed and random sensor records with random gaps and output stalls,
// one long output hold-off, and lets the frame checker score every byte.
// ----------------------------------------------------------------------------
module telemetry_frame_crc16_packer_test;
  import tfcp_pkg::*;

  logic clk;
  logic rst;
  logic rec_valid;
  logic rec_stall;
  rec_t rec;
  logic frm_valid;
  logic frm_stall;
  frm_t frm;

  int   mismatches;
  int   bytes_pending;

  // shared knobs: calm turns off random idling on both sides,
  // hold_request asks the receiver for its one long hold-off
  logic calm;
  logic hold_request;
  // receiver-private hold-off bookkeeping
  logic hold_done;
  int   hold_left;

  telemetry_frame_crc16_packer dut (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec       (rec),
    .frm_valid (frm_valid),
    .frm_stall (frm_stall),
    .frm       (frm)
  );

  tfcp_frame_checker watch (
    .clk           (clk),
    .rst           (rst),
    .rec_valid     (rec_valid),
    .rec_stall     (rec_stall),
    .rec           (rec),
    .frm_valid     (frm_valid),
    .frm_stall     (frm_stall),
    .frm           (frm),
    .mismatches    (mismatches),
    .bytes_pending (bytes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // global time limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // half fixed extremes, half random, so sign bits and all-ones patterns show up often
  function automatic logic [15:0] random_word16();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_word32();
    case ($urandom_range(7))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h0000_0000;
      2:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic rec_t random_record();
    rec_t r;
    r.temperature_tenths = 8'($urandom_range(255));
    r.accel_x      = random_word16();
    r.accel_y      = random_word16();
    r.accel_z      = random_word16();
    r.rate_x       = random_word16();
    r.rate_y       = random_word16();
    r.rate_z       = random_word16();
    r.pressure     = random_word32();
    r.timestamp_ms = random_word32();
    return r;
  endfunction

  // same 16-bit pattern in all six motion fields, pressure and its inverse as time
  function automatic rec_t uniform_record(logic [7:0] t, logic [15:0] v, logic [31:0] w);
    rec_t r;
    r.temperature_tenths = t;
    r.accel_x      = v;
    r.accel_y      = v;
    r.accel_z      = v;
    r.rate_x       = v;
    r.rate_y       = v;
    r.rate_z       = v;
    r.pressure     = w;
    r.timestamp_ms = ~w;
    return r;
  endfunction

  // offer one request; idle cycles go in front, valid then stays up until taken
  task automatic send_record(input rec_t r);
    while (!calm && $urandom_range(99) < 33) begin
      rec_valid <= 1'b0;
      @(posedge clk);
    end
    rec       <= r;
    rec_valid <= 1'b1;
    do @(posedge clk); while (rec_stall);
  endtask

  // receiver: random stalls, plus one counted hold-off long enough to back up
  // the frame serializer and the input holding register
  initial begin
    frm_stall = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        frm_stall <= 1'b1;
      end else begin
        frm_stall <= !calm && ($urandom_range(99) < 33);
      end
    end
  end

  initial begin
    rst          = 1'b1;
    rec_valid    = 1'b0;
    rec          = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: all-zero, signed max, signed min, all-ones, checker patterns,
    // ones in the low bits, values next to the sign boundary
    send_record(uniform_record(8'h00, 16'h0000, 32'h0000_0000));
    send_record(uniform_record(8'hFF, 16'h7FFF, 32'hFFFF_FFFF));
    send_record(uniform_record(8'h00, 16'h8000, 32'h0000_0000));
    send_record(uniform_record(8'hFF, 16'hFFFF, 32'h8000_0000));
    send_record(uniform_record(8'hAA, 16'hAAAA, 32'hAAAA_AAAA));
    send_record(uniform_record(8'h55, 16'h5555, 32'h5555_5555));
    send_record(uniform_record(8'h01, 16'h0001, 32'h0000_0001));
    send_record(uniform_record(8'h80, 16'h8001, 32'h7FFF_FFFF));
    send_record(uniform_record(8'h7F, 16'hFFFE, 32'h0001_0000));
    // distinct values per field to catch swapped or misordered bytes
    for (int n = 0; n < 5; n++)
      send_record(random_record());

    // random part with one long output hold-off and one stretch without idling
    for (int n = 0; n < 320; n++) begin
      if (n == 120)
        hold_request <= 1'b1;
      calm <= (n >= 200 && n < 260);
      send_record(random_record());
    end
    rec_valid <= 1'b0;

    // one edge so the checker has counted the last frame, then drain
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && bytes_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
